@@ hdl/quaternion_to_euler_angles_assert.svh @@
// Assertion macros used by the checker file of the quaternion to Euler angle converter.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define Q2E_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("q2e check failed");

// Condition that must never be seen outside reset.
`define Q2E_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("q2e check failed");

`endif

@@ hdl/q2e_pkg.sv @@
// Package with widths, types and the arctangent table of the quaternion to Euler converter.
package q2e_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int MAX_CORDIC_STAGES = 32;
  localparam int QW = 16;  // input and angle width
  localparam int PW = 32;  // product width
  localparam int OW = 35;  // atan2 operand width
  localparam int RW = 31;  // square root width
  localparam int NW = 61;  // radicand width
  localparam int CW = 38;  // CORDIC x/y width
  localparam int AW = 34;  // angle accumulator width, 2^31 is pi

  typedef struct packed {
    logic signed [OW-1:0] sr;
    logic signed [OW-1:0] cr;
    logic signed [OW-1:0] sy;
    logic signed [OW-1:0] cy;
    logic signed [OW-1:0] sp;
    logic                 cpos;
    logic                 cneg;
  } side_t;

  function automatic logic signed [AW-1:0] atan_tab(input int i);
    logic signed [AW-1:0] r;
    unique case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41721;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/quaternion_to_euler_angles.sv @@
// Quaternion to roll, pitch and yaw converter: fully pipelined, one request per cycle.
// The chain is products, sums, square, radicand, 31 square-root stages, a quadrant
// stage, one stage per CORDIC iteration and the output register.
// Throughput: one request every cycle; busy is always low.
// Synchronous reset clears all valid bits; requests in flight are dropped.
module quaternion_to_euler_angles
  import q2e_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  output logic                 done,
  output logic signed [QW-1:0] roll_angle,
  output logic signed [QW-1:0] pitch_angle,
  output logic signed [QW-1:0] yaw_angle,
  output logic                 pitch_clamped
);

  localparam int NST = (CORDIC_STAGES < MAX_CORDIC_STAGES) ? CORDIC_STAGES
                                                           : MAX_CORDIC_STAGES;
  localparam logic signed [OW-1:0] ONE = OW'(64'sd1073741824);

  assign busy = 1'b0;

  // Stage 1: products.
  logic                 v1;
  logic signed [PW-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
  end

  // Stage 2: operands of the three arctangents and the saturation test.
  logic                 v2;
  side_t                s2;
  logic [29:0]          spm2;
  logic signed [OW-1:0] sr_c, cr_c, sy_c, cy_c, sp_c, spa_c;

  always_comb begin
    sr_c  = (OW'(p_wx) + OW'(p_yz)) <<< 1;
    cr_c  = ONE - ((OW'(p_xx) + OW'(p_yy)) <<< 1);
    sy_c  = (OW'(p_wz) + OW'(p_xy)) <<< 1;
    cy_c  = ONE - ((OW'(p_yy) + OW'(p_zz)) <<< 1);
    sp_c  = (OW'(p_wy) - OW'(p_zx)) <<< 1;
    spa_c = sp_c[OW-1] ? -sp_c : sp_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2.sr   <= sr_c;
    s2.cr   <= cr_c;
    s2.sy   <= sy_c;
    s2.cy   <= cy_c;
    s2.sp   <= sp_c;
    s2.cpos <= (sp_c >= ONE);
    s2.cneg <= (sp_c <= -ONE);
    spm2    <= spa_c[29:0];
  end

  // Stage 3: square of the pitch sine; stage 4: radicand 1 - s^2.
  logic            v3;
  side_t           s3;
  logic [59:0]     sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3  <= s2;
    sq3 <= spm2 * spm2;
  end

  logic [NW-1:0] rem  [0:RW];
  logic [RW-1:0] root [0:RW];
  side_t         sd   [0:RW];
  logic          vq   [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else begin
      vq[0] <= v3;
    end
    sd[0]   <= s3;
    rem[0]  <= (NW'(1) << 60) - NW'(sq3);
    root[0] <= '0;
  end

  // Square root, one result bit per stage, most significant first.
  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    localparam int K = RW - j;
    logic [NW:0] trial;
    logic        take;

    assign trial = ((NW+1)'(root[j-1]) << (K + 1)) | ((NW+1)'(1) << (2 * K));
    assign take  = ({1'b0, rem[j-1]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[j] <= 1'b0;
      end else begin
        vq[j] <= vq[j-1];
      end
      sd[j]   <= sd[j-1];
      rem[j]  <= take ? (rem[j-1] - trial[NW-1:0]) : rem[j-1];
      root[j] <= take ? (root[j-1] | (RW'(1) << K)) : root[j-1];
    end
  end

  // CORDIC lanes: 0 is roll, 1 is pitch, 2 is yaw.
  logic signed [CW-1:0] cx   [0:NST][0:2];
  logic signed [CW-1:0] cy   [0:NST][0:2];
  logic signed [AW-1:0] ca   [0:NST][0:2];
  logic                 cz   [0:NST][0:2];
  logic [1:0]           cf   [0:NST];
  logic                 cv   [0:NST];
  logic signed [CW-1:0] lx   [0:2];
  logic signed [CW-1:0] ly   [0:2];

  always_comb begin
    lx[0] = CW'(sd[RW].cr);
    ly[0] = CW'(sd[RW].sr);
    lx[1] = $signed({{(CW-RW){1'b0}}, root[RW]});
    ly[1] = CW'(sd[RW].sp);
    lx[2] = CW'(sd[RW].cy);
    ly[2] = CW'(sd[RW].sy);
  end

  // Quadrant stage: vectors in the left half plane are turned by a quarter turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= vq[RW];
    end
    cf[0] <= {sd[RW].cpos, sd[RW].cneg};
    for (int l = 0; l < 3; l++) begin
      cz[0][l] <= (lx[l] == '0) && (ly[l] == '0);
      if (lx[l][CW-1] && !ly[l][CW-1]) begin
        cx[0][l] <= ly[l];
        cy[0][l] <= -lx[l];
        ca[0][l] <= AW'(64'sd1073741824);
      end else if (lx[l][CW-1]) begin
        cx[0][l] <= -ly[l];
        cy[0][l] <= lx[l];
        ca[0][l] <= -AW'(64'sd1073741824);
      end else begin
        cx[0][l] <= lx[l];
        cy[0][l] <= ly[l];
        ca[0][l] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      cf[i+1] <= cf[i];
      for (int l = 0; l < 3; l++) begin
        cz[i+1][l] <= cz[i][l];
        if (cy[i][l] > 0) begin
          cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
          ca[i+1][l] <= ca[i][l] + atan_tab(i);
        end else begin
          cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
          ca[i+1][l] <= ca[i][l] - atan_tab(i);
        end
      end
    end
  end

  // Output: round half up to 16 bits, force zero-length vectors to zero, then apply pitch saturation.
  logic signed [AW-1:0] rnd [0:2];
  logic signed [QW-1:0] ang [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l] = ca[NST][l] + AW'(32768);
      ang[l] = cz[NST][l] ? '0 : rnd[l][31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[NST];
    end
    roll_angle    <= ang[0];
    yaw_angle     <= ang[2];
    pitch_clamped <= cf[NST][1] | cf[NST][0];
    if (cf[NST][1]) begin
      pitch_angle <= QW'(16'sd16384);
    end else if (cf[NST][0]) begin
      pitch_angle <= -QW'(16'sd16384);
    end else begin
      pitch_angle <= ang[1];
    end
  end

endmodule

@@ hdl/q2e_checker.sv @@
// Port-level checker for the quaternion to Euler converter and its bind.
`include "quaternion_to_euler_angles_assert.svh"

module q2e_checker
  import q2e_pkg::*;
#(
  parameter int LAT = DEF_CORDIC_STAGES + 37
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic signed [QW-1:0] pitch_angle,
  input logic                 pitch_clamped
);

  // The pipeline never refuses a request.
  `Q2E_ASSERT_NEVER(a_never_busy, busy)

  // Every result traces back to a request a fixed latency earlier.
  `Q2E_ASSERT_IMPLIES(a_done_has_request, done, $past(start && !busy, LAT))

  // A saturated pitch is exactly a quarter turn.
  `Q2E_ASSERT_IMPLIES(a_clamp_value, done && pitch_clamped,
                      pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384)

  // An unsaturated pitch stays within a quarter turn.
  `Q2E_ASSERT_IMPLIES(a_pitch_range, done && !pitch_clamped,
                      pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384)

endmodule

bind quaternion_to_euler_angles q2e_checker #(
  .LAT(((CORDIC_STAGES < 32) ? CORDIC_STAGES : 32) + 37)
) u_q2e_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .pitch_angle   (pitch_angle),
  .pitch_clamped (pitch_clamped)
);
